// File: design/spsc_pkg.sv
// Shared types, codes and constants of the seat position seek controller.
`timescale 1ns / 1ps

package spsc_pkg;

	// Input opcodes
	localparam logic [1:0] OP_STATUS = 2'd0;
	localparam logic [1:0] OP_TARGET = 2'd1;
	localparam logic [1:0] OP_TICK   = 2'd2;

	// Result kinds
	localparam logic [1:0] KIND_MOTOR = 2'd0;
	localparam logic [1:0] KIND_EVENT = 2'd1;
	localparam logic [1:0] KIND_REQ   = 2'd2;

	// Motion and drive directions
	localparam logic [1:0] DIR_OFF = 2'd0;
	localparam logic [1:0] DIR_INC = 2'd1;
	localparam logic [1:0] DIR_DEC = 2'd2;

	// Request status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_UNKNOWN = 2'd2;

	// Calibration code that no frame may carry
	localparam logic [1:0] LRN_BAD = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] REG_SPEED   = 2'd0;
	localparam logic [1:0] REG_TIMEOUT = 2'd1;

	localparam logic [7:0]  POS_UNKNOWN   = 8'd255;
	localparam logic [7:0]  POS_MAX       = 8'd100;
	localparam logic [7:0]  SPEED_RESET   = 8'd50;
	localparam logic [7:0]  SPEED_BAD     = 8'd255;
	localparam logic [15:0] TIMEOUT_RESET = 16'd10000;

	localparam int SETTLE_WINDOW_MS = 500;
	localparam int TIMER_BITS_DEF   = 16;

	// Bundle queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	// Most results one item can cause
	localparam int MAX_RES = 4;
	localparam int RES_IW  = $clog2(MAX_RES);
	localparam int RES_CW  = $clog2(MAX_RES + 1);

	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] dir;
		logic [7:0] speed;
		logic [7:0] evpos;
		logic [1:0] status;
	} res_t;

	typedef struct packed {
		logic [RES_CW-1:0]       cnt;
		res_t [MAX_RES-1:0]      res;
	} bundle_t;

	function automatic res_t mk_res(logic [1:0] kind, logic [1:0] dir, logic [7:0] speed,
			logic [7:0] evpos, logic [1:0] status);
		res_t r;
		r.kind   = kind;
		r.dir    = dir;
		r.speed  = speed;
		r.evpos  = evpos;
		r.status = status;
		return r;
	endfunction

endpackage

// File: design/spsc_front.sv
// Front end: accepts items, keeps the seek state and builds the result bundle of each item.
`timescale 1ns / 1ps

module spsc_front #(
	parameter int TIMER_BITS = spsc_pkg::TIMER_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [23:0]           s_tdata,
	input  logic [1:0]            s_tuser,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [15:0]           cfg_data,
	input  logic                  q_full,
	output logic                  q_push,
	output spsc_pkg::bundle_t     q_wdata
);

	localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

	logic [7:0]            speed_q, cur_pos_q, goal_pos_q, seen_pos_q;
	logic [15:0]           timeout_q;
	logic [1:0]            cur_mot_q, goal_dir_q, seen_mot_q;
	logic                  active_q;
	logic [TIMER_BITS-1:0] elapsed_q;

	logic [7:0]            cur_pos_d, goal_pos_d, seen_pos_d;
	logic [1:0]            cur_mot_d, goal_dir_d, seen_mot_d;
	logic                  active_d;
	logic [TIMER_BITS-1:0] elapsed_d;

	logic [7:0]  pos, tgt;
	logic [1:0]  mot, lrn;
	logic        fire;
	logic        st_bad, loop_on, settle_hold, changed, reached, timed_out;
	logic [CMP_W-1:0] elapsed_x;
	logic [spsc_pkg::RES_CW-1:0] n;
	spsc_pkg::bundle_t bnd;
	logic [7:0]  cfg_speed;

	assign pos = s_tdata[7:0];
	assign mot = s_tdata[9:8];
	assign lrn = s_tdata[11:10];
	assign tgt = s_tdata[19:12];

	assign s_tready  = !q_full;
	assign cfg_ready = 1'b1;
	assign fire      = s_tvalid && s_tready;

	// Status checks run on the incoming values, which become the current ones
	assign elapsed_x   = CMP_W'(elapsed_q);
	assign st_bad      = (pos > spsc_pkg::POS_MAX && pos != spsc_pkg::POS_UNKNOWN) ||
			lrn == spsc_pkg::LRN_BAD;
	assign loop_on     = active_q && goal_dir_q != spsc_pkg::DIR_OFF &&
			goal_pos_q != spsc_pkg::POS_UNKNOWN;
	assign settle_hold = elapsed_x < CMP_W'(spsc_pkg::SETTLE_WINDOW_MS) &&
			mot == spsc_pkg::DIR_OFF && pos != goal_pos_q;
	assign changed     = seen_pos_q != pos || seen_mot_q != mot;
	assign reached     = pos != spsc_pkg::POS_UNKNOWN &&
			((goal_dir_q == spsc_pkg::DIR_INC && pos >= goal_pos_q) ||
			 (goal_dir_q == spsc_pkg::DIR_DEC && pos <= goal_pos_q));
	assign timed_out   = elapsed_x > CMP_W'(timeout_q);

	always_comb begin
		cur_pos_d  = cur_pos_q;
		cur_mot_d  = cur_mot_q;
		goal_pos_d = goal_pos_q;
		goal_dir_d = goal_dir_q;
		active_d   = active_q;
		elapsed_d  = elapsed_q;
		seen_pos_d = seen_pos_q;
		seen_mot_d = seen_mot_q;
		bnd        = '0;
		n          = '0;
		if (fire) begin
			case (s_tuser)
				spsc_pkg::OP_STATUS: begin
					if (st_bad) begin
						bnd.res[0] = spsc_pkg::mk_res(spsc_pkg::KIND_REQ, spsc_pkg::DIR_OFF,
								8'd0, 8'd0, spsc_pkg::ST_INVALID);
						n = spsc_pkg::RES_CW'(1);
					end else begin
						if (pos != cur_pos_q) begin
							bnd.res[n[spsc_pkg::RES_IW-1:0]] = spsc_pkg::mk_res(
									spsc_pkg::KIND_EVENT, spsc_pkg::DIR_OFF, 8'd0, pos,
									spsc_pkg::ST_OK);
							n = n + 1'b1;
						end
						cur_pos_d = pos;
						cur_mot_d = mot;
						if (loop_on && !settle_hold) begin
							if (changed) begin
								// Motor found stopped short: off, then resend the move
								if (mot == spsc_pkg::DIR_OFF && pos != goal_pos_q) begin
									bnd.res[n[spsc_pkg::RES_IW-1:0]] = spsc_pkg::mk_res(
											spsc_pkg::KIND_MOTOR, spsc_pkg::DIR_OFF, 8'd0,
											8'd0, spsc_pkg::ST_OK);
									n = n + 1'b1;
									bnd.res[n[spsc_pkg::RES_IW-1:0]] = spsc_pkg::mk_res(
											spsc_pkg::KIND_MOTOR, goal_dir_q, speed_q,
											8'd0, spsc_pkg::ST_OK);
									n = n + 1'b1;
								end
								seen_pos_d = pos;
								seen_mot_d = mot;
							end
							if (reached || timed_out) begin
								bnd.res[n[spsc_pkg::RES_IW-1:0]] = spsc_pkg::mk_res(
										spsc_pkg::KIND_MOTOR, spsc_pkg::DIR_OFF, 8'd0,
										8'd0, spsc_pkg::ST_OK);
								n = n + 1'b1;
								goal_pos_d = spsc_pkg::POS_UNKNOWN;
								goal_dir_d = spsc_pkg::DIR_OFF;
								active_d   = 1'b0;
								elapsed_d  = '0;
								seen_pos_d = spsc_pkg::POS_UNKNOWN;
								seen_mot_d = spsc_pkg::DIR_OFF;
							end
						end
					end
				end
				spsc_pkg::OP_TARGET: begin
					if (tgt > spsc_pkg::POS_MAX) begin
						bnd.res[0] = spsc_pkg::mk_res(spsc_pkg::KIND_REQ, spsc_pkg::DIR_OFF,
								8'd0, 8'd0, spsc_pkg::ST_INVALID);
						n = spsc_pkg::RES_CW'(1);
					end else if (cur_pos_q == spsc_pkg::POS_UNKNOWN) begin
						bnd.res[0] = spsc_pkg::mk_res(spsc_pkg::KIND_REQ, spsc_pkg::DIR_OFF,
								8'd0, 8'd0, spsc_pkg::ST_UNKNOWN);
						n = spsc_pkg::RES_CW'(1);
					end else begin
						// Always stop first
						bnd.res[0] = spsc_pkg::mk_res(spsc_pkg::KIND_MOTOR, spsc_pkg::DIR_OFF,
								8'd0, 8'd0, spsc_pkg::ST_OK);
						n = spsc_pkg::RES_CW'(1);
						goal_pos_d = spsc_pkg::POS_UNKNOWN;
						goal_dir_d = spsc_pkg::DIR_OFF;
						active_d   = 1'b0;
						elapsed_d  = '0;
						if (cur_pos_q == tgt) begin
							if (cur_mot_q != spsc_pkg::DIR_OFF) begin
								bnd.res[n[spsc_pkg::RES_IW-1:0]] = spsc_pkg::mk_res(
										spsc_pkg::KIND_MOTOR, spsc_pkg::DIR_OFF, 8'd0,
										8'd0, spsc_pkg::ST_OK);
								n = n + 1'b1;
							end
						end else begin
							goal_dir_d = (cur_pos_q < tgt) ? spsc_pkg::DIR_INC :
									spsc_pkg::DIR_DEC;
							goal_pos_d = tgt;
							active_d   = 1'b1;
							bnd.res[n[spsc_pkg::RES_IW-1:0]] = spsc_pkg::mk_res(
									spsc_pkg::KIND_MOTOR, goal_dir_d, speed_q, 8'd0,
									spsc_pkg::ST_OK);
							n = n + 1'b1;
						end
						bnd.res[n[spsc_pkg::RES_IW-1:0]] = spsc_pkg::mk_res(
								spsc_pkg::KIND_REQ, spsc_pkg::DIR_OFF, 8'd0, 8'd0,
								spsc_pkg::ST_OK);
						n = n + 1'b1;
					end
				end
				spsc_pkg::OP_TICK: begin
					// Saturating millisecond count
					if (elapsed_q != {TIMER_BITS{1'b1}}) begin
						elapsed_d = elapsed_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
		bnd.cnt = n;
	end

	assign q_push  = fire && n != '0;
	assign q_wdata = bnd;

	// Out-of-range speed codes fall back to the reset speed
	assign cfg_speed = (cfg_data[7:0] == 8'd0 || cfg_data[7:0] == spsc_pkg::SPEED_BAD) ?
			spsc_pkg::SPEED_RESET : cfg_data[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q    <= spsc_pkg::SPEED_RESET;
			timeout_q  <= spsc_pkg::TIMEOUT_RESET;
			cur_pos_q  <= spsc_pkg::POS_UNKNOWN;
			cur_mot_q  <= 2'd3;
			goal_pos_q <= spsc_pkg::POS_UNKNOWN;
			goal_dir_q <= spsc_pkg::DIR_OFF;
			active_q   <= 1'b0;
			elapsed_q  <= '0;
			seen_pos_q <= spsc_pkg::POS_UNKNOWN;
			seen_mot_q <= spsc_pkg::DIR_OFF;
		end else begin
			cur_pos_q  <= cur_pos_d;
			cur_mot_q  <= cur_mot_d;
			goal_pos_q <= goal_pos_d;
			goal_dir_q <= goal_dir_d;
			active_q   <= active_d;
			elapsed_q  <= elapsed_d;
			seen_pos_q <= seen_pos_d;
			seen_mot_q <= seen_mot_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					spsc_pkg::REG_SPEED:   speed_q   <= cfg_speed;
					spsc_pkg::REG_TIMEOUT: timeout_q <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

endmodule

// File: design/spsc_queue.sv
// Short bundle queue that decouples the front end from the result emitter.
`timescale 1ns / 1ps

module spsc_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  spsc_pkg::bundle_t wdata,
	output logic              full,
	input  logic              pop,
	output logic              rvalid,
	output spsc_pkg::bundle_t rdata
);

	spsc_pkg::bundle_t            mem_q [spsc_pkg::Q_DEPTH];
	logic [spsc_pkg::Q_AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [spsc_pkg::Q_CW-1:0]    cnt_q;
	logic                         do_push, do_pop;

	assign full    = cnt_q == spsc_pkg::Q_CW'(spsc_pkg::Q_DEPTH);
	assign rvalid  = cnt_q != '0;
	assign rdata   = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && rvalid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: design/spsc_back.sv
// Back end: unpacks each bundle into single results on the output register.
`timescale 1ns / 1ps

module spsc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_rvalid,
	input  spsc_pkg::bundle_t q_rdata,
	output logic              q_pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [23:0]       m_tdata,
	output logic [1:0]        m_tuser,
	output logic              m_tlast
);

	logic [spsc_pkg::RES_IW-1:0] idx_q;
	logic                        m_tvalid_q, m_tlast_q;
	logic [23:0]                 m_tdata_q;
	logic [1:0]                  m_tuser_q;
	logic                        slot_free, load, is_last;
	spsc_pkg::res_t              cur;

	assign slot_free = !m_tvalid_q || m_tready;
	assign load      = q_rvalid && slot_free;
	assign cur       = q_rdata.res[idx_q];
	assign is_last   = spsc_pkg::RES_CW'(idx_q) + 1'b1 == q_rdata.cnt;
	assign q_pop     = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			idx_q      <= '0;
		end else begin
			if (slot_free) begin
				m_tvalid_q <= q_rvalid;
			end
			if (load) begin
				idx_q <= is_last ? '0 : idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata_q <= {4'd0, cur.status, cur.evpos, cur.speed, cur.dir};
			m_tuser_q <= cur.kind;
			m_tlast_q <= is_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

// File: design/seat_position_seek_controller.sv
// Top level of the seat position seek controller: front end, bundle queue and emitter.
// Usage:
//   Items arrive on the s_ stream: s_tuser holds the opcode (status report, set target,
//   millisecond tick), s_tdata the status and target fields. Each transfer may cause up to
//   four results (motor commands, position change events, request status replies), sent
//   one per transfer on the m_ stream with m_tuser holding the kind and m_tlast marking
//   the final result of the item. Items with no result cause no transfer at all.
//   The cfg_ channel writes motor_speed (index 0) and move_timeout_ms (index 1); it is
//   always ready and is meant to be used only while the block is idle.
// Timing:
//   The front end evaluates an item in the cycle it is accepted, so one item per cycle
//   is taken while the bundle queue has room. Each result passes through the bundle queue
//   and then the output register, which emits the results of an item in turn, one per
//   cycle while m_tready is high, so the output register and its emitter set the sustained rate.
// Reset:
//   arst_n clears the position to unknown, drops any move, empties the queue and loads
//   the register reset values. No clearing pass is needed.
// Stalls:
//   When m_tready is low the output register holds its result, the emitter stops and the
//   four-entry queue fills; once it is full s_tready drops until results drain.
`timescale 1ns / 1ps

module seat_position_seek_controller #(
	parameter int TIMER_BITS = spsc_pkg::TIMER_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [7:0] reported_position, [9:8] reported_motion, [11:10] reported_learning,
	// [19:12] target_position, [23:20] zero
	input  logic [23:0] s_tdata,
	// [1:0] opcode
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [1:0] drive_direction, [9:2] drive_speed, [17:10] event_position,
	// [19:18] status_code, [23:20] zero
	output logic [23:0] m_tdata,
	// [1:0] kind
	output logic [1:0]  m_tuser,
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic              q_full, q_push, q_rvalid, q_pop;
	spsc_pkg::bundle_t q_wdata, q_rdata;

	// Classify items, update seek state, build result bundles
	spsc_front #(
		.TIMER_BITS(TIMER_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_wdata   (q_wdata)
	);

	// Hold bundles so either side can stall on its own
	spsc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rvalid (q_rvalid),
		.rdata  (q_rdata)
	);

	// Emit one result per transfer
	spsc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_rvalid (q_rvalid),
		.q_rdata  (q_rdata),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// A request status reply always closes the results of its item
	a_req_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == spsc_pkg::KIND_REQ |-> m_tlast)
		else $error("request status without tlast");

	// An off command never carries a speed
	a_off_no_speed: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == spsc_pkg::KIND_MOTOR && m_tdata[1:0] == spsc_pkg::DIR_OFF
		|-> m_tdata[9:2] == 8'd0)
		else $error("off command with nonzero speed");

	// Only an event carries a position
	a_evpos_only_event: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != spsc_pkg::KIND_EVENT |-> m_tdata[17:10] == 8'd0)
		else $error("position in a non-event result");

	// Emitter never pops an empty queue
	a_no_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_rvalid)
		else $error("pop from empty bundle queue");

endmodule
